/* rtl/tdbm_pkg.sv */
// ----------------------------------------------------------------------------
// tdbm_pkg: shared types and constants for the two-dimensional binned mean
// Field widths, request and register codes, bin entry layout and the
// divider command/status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package tdbm_pkg;

    localparam int COORD_W    = 17;   // unsigned Q1.16 coordinate
    localparam int WIDTH_W    = 16;   // unsigned Q0.16 bin width
    localparam int VALUE_W    = 32;   // signed Q16.16 sample / mean
    localparam int SEL_W      = 6;    // read_row / read_col
    localparam int REQ_W      = 2;
    localparam int SUM_W      = 56;
    localparam int COUNT_W    = 24;
    localparam int STEP_W     = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int DIVIDEND_W = SUM_W;
    localparam int DIVISOR_W  = COUNT_W;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [REQ_W-1:0] REQ_ADD   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ORIGIN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH   = 1'b1;

    localparam logic [COORD_W-1:0] GRID_ORIGIN_RST = 17'd655;
    localparam logic [WIDTH_W-1:0] BIN_WIDTH_RST   = 16'd1311;

    // divider step counts: bin index and mean
    localparam logic [STEP_W-1:0] AXIS_STEPS = 6'd17;
    localparam logic [STEP_W-1:0] MEAN_STEPS = 6'd56;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [COUNT_W-1:0]      count;
    } bin_entry_t;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } div_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

/* rtl/tdbm_div.sv */
// ----------------------------------------------------------------------------
// tdbm_div: shared serial restoring divider
// One quotient bit per cycle, MSB first. The dividend is left aligned by the
// caller; after N steps the low N bits of the quotient register hold the result.
// ----------------------------------------------------------------------------
`default_nettype none

module tdbm_div
    import tdbm_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire div_cmd_t              cmd,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire logic [DIVISOR_W-1:0]  divisor,
    output div_stat_t                  stat,
    output logic [DIVIDEND_W-1:0]      quotient
);

    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dsr_reg, dsr_next;
    logic [STEP_W-1:0]     cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    logic [DIVISOR_W:0]    rem_shift;
    logic [DIVISOR_W+1:0]  trial;
    logic                  fits;

    assign rem_shift = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign trial     = {1'b0, rem_shift} - {2'b00, dsr_reg};
    assign fits      = ~trial[DIVISOR_W+1];

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (cmd.start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = cmd.steps;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            rem_next = fits ? trial[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
            cnt_next = cnt_reg - STEP_W'(1);
            if (cnt_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

`default_nettype wire

/* rtl/tdbm_ram.sv */
// ----------------------------------------------------------------------------
// tdbm_ram: single-port bin store
// One access per cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tdbm_ram #(
    parameter int DEPTH  = 2500,
    parameter int ADDR_W = 12,
    parameter int DATA_W = 80
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [DATA_W-1:0] wr_data,
    output logic [DATA_W-1:0]      rd_data
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* rtl/two_dim_binned_mean_top.sv */
// An add runs up to two 17-step bin divisions, a read at most one 56-step
//   mean division, and a clear writes every bin of the BINS x BINS grid.
// Throughput: one transaction at a time; the shared serial divider sets the pace.
// Reset: synchronous, active low; afterwards a clearing pass writes every bin
//   with s_tready low; config is taken.
// ----------------------------------------------------------------------------
// two_dim_binned_mean_top: 2-D binned mean over a BINS x BINS grid
// Adds samples into bins keyed by two coordinates, reads back count and mean
// truncated toward zero, and clears the grid on request.
// ----------------------------------------------------------------------------
`default_nettype none

module two_dim_binned_mean_top
    import tdbm_pkg::*;
#(
    parameter int BINS = 50
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // configuration write port
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [COORD_W-1:0]   cfg_wr_data,
    // request channel
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // [16:0] first_coord, [33:17] second_coord, [65:34] sample_value,
    // [71:66] read_row, [77:72] read_col, [79:78] zero
    input  wire logic [79:0]          s_tdata,
    // [1:0] req_type
    input  wire logic [REQ_W-1:0]     s_tuser,
    // result channel
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [31:0] mean_value, [55:32] mode_count
    output logic [55:0]               m_tdata,
    // [0] in_grid
    output logic                      m_tuser
);

    localparam int DEPTH  = BINS * BINS;
    localparam int BIN_W  = $clog2(BINS);
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [COORD_W-1:0] BINS_Q    = COORD_W'(BINS);
    localparam logic [ADDR_W-1:0]  BINS_A    = ADDR_W'(BINS);
    localparam logic [ADDR_W-1:0]  LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam int ENTRY_W = $bits(bin_entry_t);

    // sequencer states
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_CLEAR    = 4'd1;  // one bin per cycle
    localparam logic [3:0] S_AXIS     = 4'd2;  // range check, kick off bin division
    localparam logic [3:0] S_AXIS_DIV = 4'd3;
    localparam logic [3:0] S_INDEX    = 4'd4;  // row*BINS + col
    localparam logic [3:0] S_READ     = 4'd5;  // store read in flight
    localparam logic [3:0] S_UPDATE   = 4'd6;  // accumulate, or start mean division
    localparam logic [3:0] S_MEAN_DIV = 4'd7;
    localparam logic [3:0] S_OUT      = 4'd8;

    logic [3:0]                state_reg, state_next;
    logic [COORD_W-1:0]        origin_reg, origin_next;
    logic [WIDTH_W-1:0]        width_reg, width_next;

    logic [REQ_W-1:0]          req_reg, req_next;
    logic [COORD_W-1:0]        fc_reg, fc_next;
    logic [COORD_W-1:0]        sc_reg, sc_next;
    logic signed [VALUE_W-1:0] val_reg, val_next;

    logic                      axis_sel_reg, axis_sel_next;
    logic                      clear_req_reg, clear_req_next;
    logic [BIN_W-1:0]          row_reg, row_next;
    logic [BIN_W-1:0]          col_reg, col_next;
    logic [ADDR_W-1:0]         addr_reg, addr_next;
    logic [ADDR_W-1:0]         clr_addr_reg, clr_addr_next;
    logic                      neg_reg, neg_next;

    logic                      res_flag_reg, res_flag_next;
    logic [VALUE_W-1:0]        res_mean_reg, res_mean_next;
    logic [COUNT_W-1:0]        res_count_reg, res_count_next;

    logic                      m_tvalid_reg, m_tvalid_next;
    logic [55:0]               m_tdata_reg, m_tdata_next;
    logic                      m_tuser_reg, m_tuser_next;

    // shared divider
    div_cmd_t                  div_cmd;
    div_stat_t                 div_stat;
    logic [DIVIDEND_W-1:0]     div_dividend;
    logic [DIVISOR_W-1:0]      div_divisor;
    logic [DIVIDEND_W-1:0]     div_quot;

    // bin store
    logic                      ram_we;
    logic [ADDR_W-1:0]         ram_addr;
    logic [ENTRY_W-1:0]        ram_wr_data;
    logic [ENTRY_W-1:0]        ram_rd_data;
    bin_entry_t                rd_entry;
    bin_entry_t                wr_entry;

    // axis datapath
    logic [COORD_W-1:0]        coord;
    logic [COORD_W:0]          coord_diff;
    logic [COORD_W-1:0]        offset;
    logic [COORD_W-1:0]        offset_m1;
    logic                      below_origin;
    logic [COORD_W-1:0]        axis_quot;

    // accumulate / mean datapath
    logic signed [SUM_W-1:0]   sum_new;
    logic [SUM_W-1:0]          sum_mag;
    logic [VALUE_W-1:0]        mean_mag;

    logic                      s_accept;

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;

    // offset from origin on the current axis; bin = (offset-1)/width
    assign coord        = axis_sel_reg ? sc_reg : fc_reg;
    assign coord_diff   = {1'b0, coord} - {1'b0, origin_reg};
    assign below_origin = coord_diff[COORD_W];
    assign offset       = coord_diff[COORD_W-1:0];
    assign offset_m1    = offset - COORD_W'(1);
    assign axis_quot    = div_quot[COORD_W-1:0];

    assign rd_entry = bin_entry_t'(ram_rd_data);
    assign sum_new  = rd_entry.sum
                    + {{(SUM_W-VALUE_W){val_reg[VALUE_W-1]}}, val_reg};
    // |sum| < 2^55, so the magnitude never overflows
    assign sum_mag  = rd_entry.sum[SUM_W-1] ? (~rd_entry.sum + SUM_W'(1)) : rd_entry.sum;
    assign mean_mag = div_quot[VALUE_W-1:0];

    // divider operands: mean division in S_UPDATE, bin division otherwise
    always_comb begin
        if (state_reg == S_UPDATE) begin
            div_dividend = sum_mag;
            div_divisor  = rd_entry.count;
        end else begin
            div_dividend = {offset_m1, {(DIVIDEND_W-COORD_W){1'b0}}};
            div_divisor  = DIVISOR_W'(width_reg);
        end
    end

    always_comb begin
        state_next     = state_reg;
        origin_next    = origin_reg;
        width_next     = width_reg;
        req_next       = req_reg;
        fc_next        = fc_reg;
        sc_next        = sc_reg;
        val_next       = val_reg;
        axis_sel_next  = axis_sel_reg;
        clear_req_next = clear_req_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        addr_next      = addr_reg;
        clr_addr_next  = clr_addr_reg;
        neg_next       = neg_reg;
        res_flag_next  = res_flag_reg;
        res_mean_next  = res_mean_reg;
        res_count_next = res_count_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;
        div_cmd.start  = 1'b0;
        div_cmd.steps  = AXIS_STEPS;
        ram_we         = 1'b0;
        ram_addr       = addr_reg;
        wr_entry.sum   = sum_new;
        wr_entry.count = rd_entry.count + COUNT_W'(1);

        // config writes must only arrive while idle; the block does not enforce it
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_GRID_ORIGIN: origin_next = cfg_wr_data;
                CFG_BIN_WIDTH:   width_next  = cfg_wr_data[WIDTH_W-1:0];
                default:         ;
            endcase
        end

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    req_next       = s_tuser;
                    fc_next        = s_tdata[16:0];
                    sc_next        = s_tdata[33:17];
                    val_next       = s_tdata[65:34];
                    axis_sel_next  = 1'b0;
                    res_flag_next  = 1'b0;
                    res_mean_next  = '0;
                    res_count_next = '0;
                    case (s_tuser)
                        REQ_ADD: begin
                            state_next = S_AXIS;
                        end
                        REQ_READ: begin
                            if ((COORD_W'(s_tdata[71:66]) < BINS_Q) &&
                                (COORD_W'(s_tdata[77:72]) < BINS_Q)) begin
                                row_next   = BIN_W'(s_tdata[71:66]);
                                col_next   = BIN_W'(s_tdata[77:72]);
                                state_next = S_INDEX;
                            end else begin
                                state_next = S_OUT;   // out-of-range bin reads as empty
                            end
                        end
                        REQ_CLEAR: begin
                            clr_addr_next  = '0;
                            clear_req_next = 1'b1;
                            state_next     = S_CLEAR;
                        end
                        default: begin
                            state_next = S_OUT;       // unknown request: all zero
                        end
                    endcase
                end
            end

            S_CLEAR: begin
                ram_we         = 1'b1;
                ram_addr       = clr_addr_reg;
                wr_entry.sum   = '0;
                wr_entry.count = '0;
                if (clr_addr_reg == LAST_ADDR) begin
                    state_next = clear_req_reg ? S_OUT : S_IDLE;
                end else begin
                    clr_addr_next = clr_addr_reg + ADDR_W'(1);
                end
            end

            S_AXIS: begin
                if (below_origin || ((offset != '0) && (width_reg == '0))) begin
                    state_next = S_OUT;               // dropped, in_grid stays 0
                end else if (offset == '0) begin
                    // exactly on the origin: bin 0
                    if (axis_sel_reg) begin
                        col_next   = '0;
                        state_next = S_INDEX;
                    end else begin
                        row_next      = '0;
                        axis_sel_next = 1'b1;
                    end
                end else begin
                    div_cmd.start = 1'b1;
                    div_cmd.steps = AXIS_STEPS;
                    state_next    = S_AXIS_DIV;
                end
            end

            S_AXIS_DIV: begin
                if (div_stat.done) begin
                    if (axis_quot >= BINS_Q) begin
                        state_next = S_OUT;           // beyond the last bin
                    end else if (axis_sel_reg) begin
                        col_next   = BIN_W'(axis_quot);
                        state_next = S_INDEX;
                    end else begin
                        row_next      = BIN_W'(axis_quot);
                        axis_sel_next = 1'b1;
                        state_next    = S_AXIS;
                    end
                end
            end

            S_INDEX: begin
                addr_next  = ADDR_W'(row_reg) * BINS_A + ADDR_W'(col_reg);
                state_next = S_READ;
            end

            S_READ: begin
                state_next = S_UPDATE;
            end

            S_UPDATE: begin
                if (req_reg == REQ_ADD) begin
                    res_flag_next = 1'b1;
                    // full bin: sum and count hold
                    if (rd_entry.count != COUNT_MAX) begin
                        ram_we = 1'b1;
                    end
                    state_next = S_OUT;
                end else begin
                    res_count_next = rd_entry.count;
                    if (rd_entry.count == '0) begin
                        state_next = S_OUT;
                    end else begin
                        neg_next      = rd_entry.sum[SUM_W-1];
                        div_cmd.start = 1'b1;
                        div_cmd.steps = MEAN_STEPS;
                        state_next    = S_MEAN_DIV;
                    end
                end
            end

            S_MEAN_DIV: begin
                if (div_stat.done) begin
                    // truncate toward zero: divide magnitudes, restore sign
                    res_mean_next = neg_reg ? (~mean_mag + VALUE_W'(1)) : mean_mag;
                    state_next    = S_OUT;
                end
            end

            S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {res_count_reg, res_mean_reg};
                    m_tuser_next  = res_flag_reg;
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign ram_wr_data = wr_entry;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;       // clearing pass after reset
            origin_reg    <= GRID_ORIGIN_RST;
            width_reg     <= BIN_WIDTH_RST;
            axis_sel_reg  <= 1'b0;
            clear_req_reg <= 1'b0;
            clr_addr_reg  <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            origin_reg    <= origin_next;
            width_reg     <= width_next;
            axis_sel_reg  <= axis_sel_next;
            clear_req_reg <= clear_req_next;
            clr_addr_reg  <= clr_addr_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg       <= req_next;
        fc_reg        <= fc_next;
        sc_reg        <= sc_next;
        val_reg       <= val_next;
        row_reg       <= row_next;
        col_reg       <= col_next;
        addr_reg      <= addr_next;
        neg_reg       <= neg_next;
        res_flag_reg  <= res_flag_next;
        res_mean_reg  <= res_mean_next;
        res_count_reg <= res_count_next;
        m_tdata_reg   <= m_tdata_next;
        m_tuser_reg   <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    tdbm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (div_cmd),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_quot)
    );

    tdbm_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (ENTRY_W)
    ) u_ram (
        .aclk    (aclk),
        .we      (ram_we),
        .addr    (ram_addr),
        .wr_data (ram_wr_data),
        .rd_data (ram_rd_data)
    );

`ifndef ASSERT_OFF
    // the divider is never left running when a new transaction can come in
    a_idle_div_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !div_stat.busy)
        else $error("divider busy while accepting");

    // the store is only written by the clearing pass or an accumulate
    a_ram_write_state: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == S_CLEAR || state_reg == S_UPDATE))
        else $error("store write outside clear/update");

    // divider results only land where the sequencer waits for them
    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> (state_reg == S_AXIS_DIV || state_reg == S_MEAN_DIV))
        else $error("divider done in unexpected state");

    // an in-grid add result never carries mean or count
    a_add_result_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tuser_reg) |-> (m_tdata_reg == '0))
        else $error("in_grid result with nonzero data");
`endif

endmodule

`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for two_dim_binned_mean_top
// Drives add, read, clear and unknown requests over several grid settings
// and checks results against a bin-accurate scoreboard model or hand-written ones.
// ----------------------------------------------------------------------------

module testbench
    import tdbm_pkg::*;
();

    localparam int NBINS           = 50;
    localparam int N_PHASES        = 7;
    localparam int RAND_PER_PHASE  = 160;
    localparam int DRAIN_CYCLES    = 100;   // longer than the read latency
    localparam int WATCHDOG_LIMIT  = 20000; // covers a clear plus the post-reset pass
    localparam int QUIET_PHASE     = 3;     // phase run with both sides always ready
    localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0]          req;
        logic [COORD_W-1:0]        row_coord;
        logic [COORD_W-1:0]        col_coord;
        logic signed [VALUE_W-1:0] sample;
        logic [SEL_W-1:0]          rd_row;
        logic [SEL_W-1:0]          rd_col;
    } grid_req_t;

    typedef struct packed {
        logic               in_grid;
        logic [VALUE_W-1:0] mean;
        logic [COUNT_W-1:0] count;
    } bin_result_t;

    typedef struct packed {
        grid_req_t   rq;
        logic        typed;   // want holds a hand-written result
        bin_result_t want;
    } dir_vec_t;

    // ------------------------------------------------------------------------
    // Directed vectors, default grid (origin 655, width 1311, top edge 66205)
    // ------------------------------------------------------------------------
    localparam int N_DIR = 25;
    dir_vec_t dir_vec [N_DIR] = '{
        // read after reset: empty bin
        '{'{REQ_READ, 17'd0, 17'd0, 32'h0, 6'd0, 6'd0}, 1'b1, '{1'b0, 32'h0, 24'd0}},
        // exactly on the origin: bin (0,0), largest value
        '{'{REQ_ADD, 17'd655, 17'd655, 32'h7FFFFFFF, 6'd0, 6'd0}, 1'b1, '{1'b1, 32'h0, 24'd0}},
        // row coordinate one below the origin
        '{'{REQ_ADD, 17'd654, 17'd1000, 32'h1, 6'd0, 6'd0}, 1'b1, '{1'b0, 32'h0, 24'd0}},
        // upper edge of the last bin on both axes, most negative value
        '{'{REQ_ADD, 17'd66205, 17'd66205, 32'h80000000, 6'd0, 6'd0}, 1'b1,
          '{1'b1, 32'h0, 24'd0}},
        // one past the last bin
        '{'{REQ_ADD, 17'd66206, 17'd655, 32'hFFFFFFFF, 6'd0, 6'd0}, 1'b1,
          '{1'b0, 32'h0, 24'd0}},
        // row in range, column far beyond the grid
        '{'{REQ_ADD, 17'd700, 17'd70000, 32'h3, 6'd0, 6'd0}, 1'b1, '{1'b0, 32'h0, 24'd0}},
        '{'{REQ_ADD, 17'h1FFFF, 17'h1FFFF, 32'h5, 6'd0, 6'd0}, 1'b1, '{1'b0, 32'h0, 24'd0}},
        '{'{REQ_ADD, 17'd0, 17'd0, 32'h7, 6'd0, 6'd0}, 1'b1, '{1'b0, 32'h0, 24'd0}},
        // upper edge of bin 0 on the column axis
        '{'{REQ_ADD, 17'd655, 17'd1966, 32'hFFFFFFFB, 6'd0, 6'd0}, 1'b0, '0},
        // first coordinate of bin 1 on the row axis
        '{'{REQ_ADD, 17'd1967, 17'd655, 32'd100, 6'd0, 6'd0}, 1'b0, '0},
        '{'{REQ_READ, 17'd0, 17'd0, 32'h0, 6'd0, 6'd0}, 1'b0, '0},
        '{'{REQ_READ, 17'd0, 17'd0, 32'h0, 6'd49, 6'd49}, 1'b1,
          '{1'b0, 32'h80000000, 24'd1}},
        // reads outside the grid look like empty bins
        '{'{REQ_READ, 17'd0, 17'd0, 32'h0, 6'd50, 6'd0}, 1'b1, '{1'b0, 32'h0, 24'd0}},
        '{'{REQ_READ, 17'd0, 17'd0, 32'h0, 6'd0, 6'd63}, 1'b1, '{1'b0, 32'h0, 24'd0}},
        // unknown request, all fields high
        '{'{REQ_UNKNOWN, 17'h1FFFF, 17'h1FFFF, 32'hFFFFFFFF, 6'h3F, 6'h3F}, 1'b1,
          '{1'b0, 32'h0, 24'd0}},
        // negative running sum: mean truncates toward zero
        '{'{REQ_ADD, 17'd1967, 17'd655, 32'hFFFFFFF9, 6'd0, 6'd0}, 1'b0, '0},
        '{'{REQ_ADD, 17'd1967, 17'd655, 32'hFFFFFF38, 6'd0, 6'd0}, 1'b0, '0},
        '{'{REQ_READ, 17'd0, 17'd0, 32'h0, 6'd1, 6'd0}, 1'b0, '0},
        '{'{REQ_ADD, 17'd655, 17'd65000, 32'h12345678, 6'd0, 6'd0}, 1'b0, '0},
        '{'{REQ_READ, 17'd0, 17'd0, 32'h0, 6'd0, 6'd49}, 1'b0, '0},
        '{'{REQ_READ, 17'd0, 17'd0, 32'h0, 6'd63, 6'd0}, 1'b1, '{1'b0, 32'h0, 24'd0}},
        '{'{REQ_CLEAR, 17'd0, 17'd0, 32'h0, 6'd0, 6'd0}, 1'b1, '{1'b0, 32'h0, 24'd0}},
        '{'{REQ_READ, 17'd0, 17'd0, 32'h0, 6'd0, 6'd0}, 1'b1, '{1'b0, 32'h0, 24'd0}},
        '{'{REQ_READ, 17'd0, 17'd0, 32'h0, 6'd49, 6'd49}, 1'b1, '{1'b0, 32'h0, 24'd0}},
        '{'{REQ_ADD, 17'd655, 17'd655, 32'h0, 6'd0, 6'd0}, 1'b1, '{1'b1, 32'h0, 24'd0}}
    };

    // grid settings per phase: extremes, zero width, one picked at run time
    logic [COORD_W-1:0] phase_origin [N_PHASES] =
        '{17'd655, 17'd0, 17'h1FFFF, 17'd0, 17'd1000, 17'd0, 17'd123};
    logic [WIDTH_W-1:0] phase_width  [N_PHASES] =
        '{16'd1311, 16'd1, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd2621};

    // ------------------------------------------------------------------------
    // DUT signals; every input is known from time zero
    // ------------------------------------------------------------------------
    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index   = CFG_GRID_ORIGIN;
    logic [COORD_W-1:0]   cfg_wr_data = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [79:0]          s_tdata     = '0;
    logic [REQ_W-1:0]     s_tuser     = REQ_ADD;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [55:0]          m_tdata;
    logic                 m_tuser;

    logic idle_on = 1'b1;   // random idling on both sides
    int   mismatches = 0;
    int   stall_cycles = 0;

    // scoreboard copy of the grid and its settings
    logic [COORD_W-1:0]      grid_org;
    logic [WIDTH_W-1:0]      bin_w;
    logic signed [SUM_W-1:0] bin_sum [NBINS*NBINS];
    logic [COUNT_W-1:0]      bin_cnt [NBINS*NBINS];
    bin_result_t             pending_results [$];

    int hot_bins [4] = '{0, 1, 25, NBINS-1};

    two_dim_binned_mean_top #(.BINS(NBINS)) DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Scoreboard model
    // ------------------------------------------------------------------------

    // bin on one axis; a coordinate on the origin always lands in bin 0
    function automatic logic axis_slot(input logic [COORD_W-1:0] coord, output int slot);
        logic [COORD_W-1:0] offs;
        if (coord < grid_org) return 1'b0;
        offs = coord - grid_org;
        if (offs == 0) begin
            slot = 0;
            return 1'b1;
        end
        if (bin_w == 0) return 1'b0;
        slot = int'((offs - COORD_W'(1)) / bin_w);
        return slot < NBINS;
    endfunction

    function automatic bin_result_t apply_request(input grid_req_t rq);
        bin_result_t res;
        int          r_bin;
        int          c_bin;
        int          idx;
        longint      tot;
        longint      num;
        longint      quot;
        res = '0;
        case (rq.req)
            REQ_ADD: begin
                if (axis_slot(rq.row_coord, r_bin) && axis_slot(rq.col_coord, c_bin)) begin
                    idx = r_bin * NBINS + c_bin;
                    res.in_grid = 1'b1;
                    // a full bin keeps its sum and count
                    if (bin_cnt[idx] != COUNT_MAX) begin
                        bin_sum[idx] = bin_sum[idx] + SUM_W'(rq.sample);
                        bin_cnt[idx] = bin_cnt[idx] + COUNT_W'(1);
                    end
                end
            end
            REQ_READ: begin
                if (rq.rd_row < NBINS && rq.rd_col < NBINS) begin
                    idx = rq.rd_row * NBINS + rq.rd_col;
                    res.count = bin_cnt[idx];
                    if (bin_cnt[idx] != 0) begin
                        tot  = bin_sum[idx];
                        num  = {40'd0, bin_cnt[idx]};
                        quot = tot / num;   // truncates toward zero
                        res.mean = quot[VALUE_W-1:0];
                    end
                end
            end
            REQ_CLEAR: begin
                for (int i = 0; i < NBINS*NBINS; i++) begin
                    bin_sum[i] = '0;
                    bin_cnt[i] = '0;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // mostly a handful of busy bins so that counts and sums build up
    function automatic int pick_bin();
        if ($urandom_range(0, 3) == 0) return $urandom_range(0, NBINS-1);
        return hot_bins[$urandom_range(0, 3)];
    endfunction

    // coordinate inside bin b of the current grid or on its origin, clipped to the field range
    function automatic logic [COORD_W-1:0] coord_in_bin(input int b);
        int c;
        if (bin_w == 0 || $urandom_range(0, 9) == 0)
            c = int'(grid_org);
        else
            c = int'(grid_org) + b * int'(bin_w) + int'($urandom_range(1, bin_w));
        if (c > 131071) c = 131071;
        return c[COORD_W-1:0];
    endfunction

    // both registers back to back; after the first phase the block is idle here
    task automatic set_grid(input logic [COORD_W-1:0] org, input logic [WIDTH_W-1:0] w);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= CFG_GRID_ORIGIN;
        cfg_wr_data <= org;
        @(posedge aclk);
        cfg_index   <= CFG_BIN_WIDTH;
        cfg_wr_data <= {1'b0, w};
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        grid_org = org;
        bin_w    = w;
    endtask

    // one request transaction; valid is left high for the caller to drop
    task automatic send_req(input grid_req_t rq, input logic typed, input bin_result_t want);
        bin_result_t res;
        while (idle_on && $urandom_range(0, 99) < 32) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= rq.req;
        s_tdata  <= {2'b00, rq.rd_col, rq.rd_row, rq.sample, rq.col_coord, rq.row_coord};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        // accepted at this edge; its result comes back no earlier than the
        // next cycles, so the queue order holds against the checker
        res = apply_request(rq);
        pending_results.push_back(typed ? want : res);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        grid_req_t rq;
        int        pick;
        for (int i = 0; i < NBINS*NBINS; i++) begin
            bin_sum[i] = '0;
            bin_cnt[i] = '0;
        end
        grid_org = GRID_ORIGIN_RST;
        bin_w    = BIN_WIDTH_RST;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        for (int p = 0; p < N_PHASES; p++) begin
            if (p > 0) begin
                // let every outstanding result drain before touching the grid
                s_tvalid <= 1'b0;
                while (pending_results.size() != 0) @(posedge aclk);
            end
            idle_on <= (p != QUIET_PHASE);
            if (p == 5) begin
                phase_origin[p] = COORD_W'($urandom_range(0, 20000));
                phase_width[p]  = WIDTH_W'($urandom_range(100, 2600));
            end
            set_grid(phase_origin[p], phase_width[p]);

            if (p == 0) begin
                for (int i = 0; i < N_DIR; i++)
                    send_req(dir_vec[i].rq, dir_vec[i].typed, dir_vec[i].want);
            end

            // random mix: mostly in-grid adds and reads of busy bins, some noise
            for (int n = 0; n < RAND_PER_PHASE; n++) begin
                rq.row_coord = COORD_W'($urandom);
                rq.col_coord = COORD_W'($urandom);
                rq.sample    = $urandom;
                rq.rd_row    = SEL_W'($urandom);
                rq.rd_col    = SEL_W'($urandom);
                pick = $urandom_range(0, 99);
                if (pick < 1) begin
                    rq.req = REQ_CLEAR;
                end else if (pick < 4) begin
                    rq.req = REQ_UNKNOWN;
                end else if (pick < 40) begin
                    rq.req = REQ_READ;
                    if ($urandom_range(0, 4) != 0) begin
                        rq.rd_row = SEL_W'(pick_bin());
                        rq.rd_col = SEL_W'(pick_bin());
                    end
                end else begin
                    rq.req = REQ_ADD;
                    if ($urandom_range(0, 4) != 0) begin
                        rq.row_coord = coord_in_bin(pick_bin());
                        rq.col_coord = coord_in_bin(pick_bin());
                    end
                end
                send_req(rq, 1'b0, '0);
            end
        end

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: random back-pressure and checking
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        m_tready <= idle_on ? ($urandom_range(0, 99) >= 32) : 1'b1;
    end

    always @(posedge aclk) begin
        bin_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result transaction: in_grid %0b mean %h count %0d",
                         $time, m_tuser, m_tdata[31:0], m_tdata[55:32]);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (m_tuser !== want.in_grid) begin
                    $display("%0t: in_grid mismatch: expected %0b, actual %0b",
                             $time, want.in_grid, m_tuser);
                    mismatches++;
                end
                if (m_tdata[31:0] !== want.mean) begin
                    $display("%0t: mean_value mismatch: expected %h, actual %h",
                             $time, want.mean, m_tdata[31:0]);
                    mismatches++;
                end
                if (m_tdata[55:32] !== want.count) begin
                    $display("%0t: mode_count mismatch: expected %0d, actual %0d",
                             $time, want.count, m_tdata[55:32]);
                    mismatches++;
                end
            end
        end
    end

    // watchdog: too long without any transaction on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

endmodule

/* two_dim_binned_mean_top.f */
rtl/tdbm_pkg.sv
rtl/tdbm_div.sv
rtl/tdbm_ram.sv
rtl/two_dim_binned_mean_top.sv
test/testbench.sv
